### rtl/lpr_pkg.sv
package lpr_pkg;

	// route table geometry
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// field widths
	localparam int ADDR_W  = 32;
	localparam int LEN_W   = 6;
	localparam int IFACE_W = 3;
	localparam int TTL_W   = 8;
	localparam int STAT_W  = 3;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

	// command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [STAT_W-1:0] {
		ST_FORWARDED = 3'd0,
		ST_NO_ROUTE  = 3'd1,
		ST_TTL       = 3'd2,
		ST_ADDED     = 3'd3,
		ST_FULL      = 3'd4
	} lpr_status_t;

	typedef enum logic {
		REQ_ADD   = 1'b0,
		REQ_ROUTE = 1'b1
	} lpr_req_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_RESP
	} lpr_bk_state_t;

	// classified command handed from front to back
	typedef struct packed {
		lpr_req_kind_t       kind;
		logic [ADDR_W-1:0]   address;
		logic [LEN_W-1:0]    plen;
		logic                has_hop;
		logic [ADDR_W-1:0]   hop;
		logic [IFACE_W-1:0]  iface;
		logic [TTL_W-1:0]    ttl;
	} lpr_cmd_t;

	// one stored route
	typedef struct packed {
		logic [ADDR_W-1:0]   prefix;
		logic [LEN_W-1:0]    plen;
		logic                has_hop;
		logic [ADDR_W-1:0]   hop;
		logic [IFACE_W-1:0]  iface;
	} lpr_entry_t;

	// high plen bits set, plen in 0..32
	function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] plen);
		logic [ADDR_W-1:0] m;
		if (plen == '0) begin
			m = '0;
		end else begin
			m = {ADDR_W{1'b1}} << (MAX_LEN - plen);
		end
		return m;
	endfunction

endpackage

### rtl/lpr_if.sv
interface lpr_req_if import lpr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [ADDR_W-1:0]   address;
	logic [LEN_W-1:0]    prefix_len;
	logic                has_next_hop;
	logic [ADDR_W-1:0]   gateway_addr;
	logic [IFACE_W-1:0]  iface_in;
	logic [TTL_W-1:0]    ttl_in;

	modport source (
		output valid, req_type, address, prefix_len, has_next_hop,
		       gateway_addr, iface_in, ttl_in,
		input  ready
	);
	modport sink (
		input  valid, req_type, address, prefix_len, has_next_hop,
		       gateway_addr, iface_in, ttl_in,
		output ready
	);
endinterface

interface lpr_rsp_if import lpr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic [IFACE_W-1:0]  iface_out;
	logic [ADDR_W-1:0]   hop_addr_out;
	logic [TTL_W-1:0]    ttl_out;

	modport source (
		output valid, status, iface_out, hop_addr_out, ttl_out,
		input  ready
	);
	modport sink (
		input  valid, status, iface_out, hop_addr_out, ttl_out,
		output ready
	);
endinterface

### rtl/lpr_front.sv
module lpr_front import lpr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	lpr_req_if.sink  req,
	output lpr_cmd_t cmd,
	output logic     cmd_valid,
	input  logic     cmd_ready
);

	logic     hold_valid_q;
	lpr_cmd_t hold_q;
	lpr_cmd_t cls;
	logic     accept;

	assign req.ready = !hold_valid_q || cmd_ready;
	assign accept    = req.valid && req.ready;

	// classify and clamp the prefix length
	always_comb begin
		cls.kind    = lpr_req_kind_t'(req.req_type);
		cls.address = req.address;
		cls.plen    = (req.prefix_len > MAX_LEN) ? MAX_LEN : req.prefix_len;
		cls.has_hop = req.has_next_hop;
		cls.hop     = req.gateway_addr;
		cls.iface   = req.iface_in;
		cls.ttl     = req.ttl_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (req.ready) begin
			hold_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q <= cls;
		end
	end

	assign cmd       = hold_q;
	assign cmd_valid = hold_valid_q;

endmodule

### rtl/lpr_queue.sv
module lpr_queue import lpr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  lpr_cmd_t in_cmd,
	input  logic     in_valid,
	output logic     in_ready,
	output lpr_cmd_t out_cmd,
	output logic     out_valid,
	input  logic     out_ready
);

	lpr_cmd_t             slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 push;
	logic                 pop;

	assign in_ready  = cnt_q != Q_CNT_W'(Q_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_cmd   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= Q_PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= Q_PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= Q_CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= Q_CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

### rtl/lpr_back.sv
module lpr_back import lpr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lpr_cmd_t  cmd,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	lpr_rsp_if.source rsp
);

	lpr_bk_state_t       state_q, state_d;
	lpr_cmd_t            cur_q;
	lpr_entry_t          table_q [TABLE_DEPTH];
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    idx_q;
	logic                found_q;
	logic [LEN_W-1:0]    best_len_q;
	logic [IFACE_W-1:0]  best_iface_q;
	logic [ADDR_W-1:0]   best_hop_q;

	logic                rsp_valid_q;
	lpr_status_t         status_q;
	logic [IFACE_W-1:0]  iface_q;
	logic [ADDR_W-1:0]   hop_q;
	logic [TTL_W-1:0]    ttl_q;

	lpr_entry_t          entry;
	logic [ADDR_W-1:0]   mask;
	logic                hit, better, last, full, out_free;
	logic                start, step, finish, do_write;
	lpr_status_t         status_d;
	logic [IFACE_W-1:0]  iface_d;
	logic [ADDR_W-1:0]   hop_d;
	logic [TTL_W-1:0]    ttl_d;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign full     = count_q == CNT_W'(TABLE_DEPTH);

	// one entry compared per cycle
	assign entry  = table_q[idx_q];
	assign mask   = len_mask(entry.plen);
	assign hit    = (entry.prefix & mask) == (cur_q.address & mask);
	assign better = hit && (!found_q || entry.plen > best_len_q);
	assign last   = CNT_W'(idx_q) == CNT_W'(count_q - 1'b1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == REQ_ROUTE && count_q != '0) begin
						state_d = BK_SCAN;
					end else begin
						state_d = BK_RESP;
					end
				end
			end
			BK_SCAN: begin
				if (last) begin
					state_d = BK_RESP;
				end
			end
			BK_RESP: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = 1'b0;
		step      = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			BK_IDLE: cmd_ready = 1'b1;
			BK_SCAN: step      = 1'b1;
			BK_RESP: finish    = out_free;
			default: ;
		endcase
	end

	assign start    = cmd_valid && cmd_ready;
	assign do_write = finish && cur_q.kind == REQ_ADD && !full;

	// result word, fields zero unless forwarded
	always_comb begin
		status_d = ST_FORWARDED;
		iface_d  = '0;
		hop_d    = '0;
		ttl_d    = '0;
		if (cur_q.kind == REQ_ADD) begin
			status_d = full ? ST_FULL : ST_ADDED;
		end else if (!found_q) begin
			status_d = ST_NO_ROUTE;
		end else if (cur_q.ttl <= TTL_W'(1)) begin
			status_d = ST_TTL;
		end else begin
			iface_d = best_iface_q;
			hop_d   = best_hop_q;
			ttl_d   = TTL_W'(cur_q.ttl - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (step) begin
				idx_q <= IDX_W'(idx_q + 1'b1);
				if (better) begin
					found_q <= 1'b1;
				end
			end
			if (do_write) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= cmd;
		end
		if (step && better) begin
			best_len_q   <= entry.plen;
			best_iface_q <= entry.iface;
			best_hop_q   <= entry.has_hop ? entry.hop : cur_q.address;
		end
		if (finish) begin
			status_q <= status_d;
			iface_q  <= iface_d;
			hop_q    <= hop_d;
			ttl_q    <= ttl_d;
		end
		if (do_write) begin
			table_q[count_q[IDX_W-1:0]] <= '{
				prefix:  cur_q.address,
				plen:    cur_q.plen,
				has_hop: cur_q.has_hop,
				hop:     cur_q.hop,
				iface:   cur_q.iface
			};
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.iface_out    = iface_q;
	assign rsp.hop_addr_out = hop_q;
	assign rsp.ttl_out      = ttl_q;

endmodule

### rtl/ipv4_longest_prefix_router_unit.sv
// channel | dir | fields                                                     | handshake
// req     | in  | req_type address prefix_len has_next_hop gateway_addr     | valid/ready
//         |     | iface_in ttl_in                                            |
// rsp     | out | status iface_out hop_addr_out ttl_out                      | valid/ready
//
// in the back end an add goes from idle straight to the response state, and a lookup
// first scans a non-empty table: the back end compares one stored route a cycle
// front register and a two-word queue take new words while the back end scans
// a finished result waits in the output register without holding up the queue
// arst_n empties the route table (count to zero), queue and output register

module ipv4_longest_prefix_router_unit import lpr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lpr_req_if.sink   req,
	lpr_rsp_if.source rsp
);

	// front to queue
	lpr_cmd_t fr_cmd;
	logic     fr_valid;
	logic     fr_ready;

	// queue to back end
	lpr_cmd_t bk_cmd;
	logic     bk_valid;
	logic     bk_ready;

	// accept and classify, clamp prefix length to 32
	lpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (fr_cmd),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready)
	);

	// decouples acceptance from the table scan
	lpr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_cmd    (fr_cmd),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.out_cmd   (bk_cmd),
		.out_valid (bk_valid),
		.out_ready (bk_ready)
	);

	// route table, sequential longest-prefix scan, result register
	lpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (bk_cmd),
		.cmd_valid (bk_valid),
		.cmd_ready (bk_ready),
		.rsp       (rsp)
	);

endmodule

### rtl/lpr_checker.sv
module lpr_checker import lpr_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STAT_W-1:0]   rsp_status,
	input logic [IFACE_W-1:0]  rsp_iface_out,
	input logic [ADDR_W-1:0]   rsp_hop_addr_out,
	input logic [TTL_W-1:0]    rsp_ttl_out
);

	// stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// stalled result word unchanged
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_hop_addr_out)
			&& $stable(rsp_iface_out) && $stable(rsp_ttl_out))
		else $error("result word changed while stalled");

	// only forwarded datagrams carry route fields
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_FORWARDED |->
			rsp_iface_out == '0 && rsp_hop_addr_out == '0 && rsp_ttl_out == '0)
		else $error("non-forwarded result carries route fields");

	// decremented ttl never wraps
	a_ttl_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FORWARDED |-> rsp_ttl_out != '1)
		else $error("forwarded ttl wrapped");

endmodule

bind ipv4_longest_prefix_router_unit lpr_checker u_lpr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_iface_out    (rsp.iface_out),
	.rsp_hop_addr_out (rsp.hop_addr_out),
	.rsp_ttl_out      (rsp.ttl_out)
);

### tb/lpr_route_checker.sv
`timescale 1ns / 100ps

module lpr_route_checker import lpr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	lpr_req_if   req,
	lpr_rsp_if   rsp,
	output int   mismatches,
	output int   pending,
	output int   tally [5]
);

	typedef struct packed {
		lpr_status_t        status;
		logic [IFACE_W-1:0] iface;
		logic [ADDR_W-1:0]  hop;
		logic [TTL_W-1:0]   ttl;
	} fwd_verdict_t;

	localparam int REPORT_MAX = 10;
	localparam logic [LEN_W-1:0] LONGEST = LEN_W'(ADDR_W);

	lpr_entry_t   fib [TABLE_DEPTH];
	int           fib_used;
	fwd_verdict_t verdicts_due [$];
	lpr_cmd_t     word_in;
	fwd_verdict_t want;

	// high plen bits set, plen already clamped
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] plen);
		return ~({ADDR_W{1'b1}} >> plen);
	endfunction

	// store a route or look one up, giving the answer the block owes
	function automatic fwd_verdict_t forward_or_learn(input lpr_cmd_t w);
		fwd_verdict_t      v;
		logic [ADDR_W-1:0] m;
		int                best;
		v = '0;
		if (w.kind == REQ_ADD) begin
			if (fib_used >= TABLE_DEPTH) begin
				v.status = ST_FULL;
			end else begin
				fib[fib_used].prefix  = w.address;
				fib[fib_used].plen    = (w.plen > LONGEST) ? LONGEST : w.plen;
				fib[fib_used].has_hop = w.has_hop;
				fib[fib_used].hop     = w.hop;
				fib[fib_used].iface   = w.iface;
				fib_used++;
				v.status = ST_ADDED;
			end
		end else begin
			best = -1;
			// strictly longer wins, so the earliest of equal lengths stays
			for (int i = 0; i < fib_used; i++) begin
				m = prefix_mask(fib[i].plen);
				if ((fib[i].prefix & m) == (w.address & m) &&
				    (best < 0 || fib[i].plen > fib[best].plen)) begin
					best = i;
				end
			end
			if (best < 0) begin
				v.status = ST_NO_ROUTE;
			end else if (w.ttl <= 1) begin
				v.status = ST_TTL;
			end else begin
				v.status = ST_FORWARDED;
				v.iface  = fib[best].iface;
				v.hop    = fib[best].has_hop ? fib[best].hop : w.address;
				v.ttl    = w.ttl - 1'b1;
			end
		end
		return v;
	endfunction

	task automatic report_bad(input string what, input fwd_verdict_t w);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("%0t: %s: status %0d/%0d iface %0d/%0d hop %h/%h ttl %0d/%0d (exp/act)",
			         $realtime, what, w.status, rsp.status, w.iface, rsp.iface_out,
			         w.hop, rsp.hop_addr_out, w.ttl, rsp.ttl_out);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fib_used = 0;
			verdicts_due.delete();
			pending    = 0;
			mismatches = 0;
		end else begin
			if (req.valid && req.ready) begin
				word_in.kind    = lpr_req_kind_t'(req.req_type);
				word_in.address = req.address;
				word_in.plen    = req.prefix_len;
				word_in.has_hop = req.has_next_hop;
				word_in.hop     = req.gateway_addr;
				word_in.iface   = req.iface_in;
				word_in.ttl     = req.ttl_in;
				verdicts_due.insert(verdicts_due.size(), forward_or_learn(word_in));
			end
			if (rsp.valid && rsp.ready) begin
				if (verdicts_due.size() == 0) begin
					report_bad("result word with nothing expected", '0);
				end else begin
					want = verdicts_due.pop_front();
					tally[int'(want.status)]++;
					if (rsp.status !== want.status || rsp.iface_out !== want.iface ||
					    rsp.hop_addr_out !== want.hop || rsp.ttl_out !== want.ttl) begin
						report_bad("result word mismatch", want);
					end
				end
			end
			pending = verdicts_due.size();
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import lpr_pkg::*;

	localparam int WORDS_RANDOM = 2000;
	localparam int IDLE_PCT     = 36;
	localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
	localparam int QUIET_LIMIT  = 5000;  // cycles with no word moving on either side
	localparam int DRAIN_CYCLES = 50;    // longer than a full-table scan

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #2 clk = ~clk;

	lpr_req_if req_ch ();
	lpr_rsp_if rsp_ch ();

	ipv4_longest_prefix_router_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	int mismatches;
	int pending;
	int tally [5];

	// checker sits beside the block and predicts every result word
	lpr_route_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.tally      (tally)
	);

	bit calm;       // no idling on either side while set
	bit hold_rsp;   // asks the receiver for one long hold-off
	int words_sent;
	int quiet;

	// routes as sent while the table had room, used to aim destinations at it
	logic [ADDR_W-1:0] sent_prefix [TABLE_DEPTH];
	logic [LEN_W-1:0]  sent_len    [TABLE_DEPTH];
	int                routes_sent;

	// high bits of a stored length, lengths above 32 clamped as the block does
	function automatic logic [ADDR_W-1:0] aim_mask(input logic [LEN_W-1:0] plen);
		int l;
		l = (plen > ADDR_W) ? ADDR_W : int'(plen);
		return ~({ADDR_W{1'b1}} >> l);
	endfunction

	// offer one request word, idling first at random, and wait for acceptance
	task automatic offer(input lpr_cmd_t w);
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_ch.valid         <= 1'b1;
		req_ch.req_type      <= w.kind;
		req_ch.address       <= w.address;
		req_ch.prefix_len    <= w.plen;
		req_ch.has_next_hop  <= w.has_hop;
		req_ch.gateway_addr  <= w.hop;
		req_ch.iface_in      <= w.iface;
		req_ch.ttl_in        <= w.ttl;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		words_sent++;
		// adds fill the table in order until it is full
		if (w.kind == REQ_ADD && routes_sent < TABLE_DEPTH) begin
			sent_prefix[routes_sent] = w.address;
			sent_len[routes_sent]    = w.plen;
			routes_sent++;
		end
	endtask

	// unused fields (ttl here) get random values, the block must ignore them
	task automatic learn_route(input logic [ADDR_W-1:0] prefix, input logic [LEN_W-1:0] plen,
	                           input logic has_hop, input logic [ADDR_W-1:0] hop,
	                           input logic [IFACE_W-1:0] iface);
		lpr_cmd_t w;
		w.kind    = REQ_ADD;
		w.address = prefix;
		w.plen    = plen;
		w.has_hop = has_hop;
		w.hop     = hop;
		w.iface   = iface;
		w.ttl     = TTL_W'($urandom);
		offer(w);
	endtask

	// route fields of an add are random noise on a lookup
	task automatic route_dgram(input logic [ADDR_W-1:0] dest, input logic [TTL_W-1:0] ttl);
		lpr_cmd_t w;
		w.kind    = REQ_ROUTE;
		w.address = dest;
		w.plen    = LEN_W'($urandom);
		w.has_hop = 1'($urandom);
		w.hop     = $urandom;
		w.iface   = IFACE_W'($urandom);
		w.ttl     = ttl;
		offer(w);
	endtask

	// mostly lookups aimed at stored prefixes, adds nested inside or beside them
	task automatic random_word();
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] m;
		logic [LEN_W-1:0]  plen;
		logic [TTL_W-1:0]  ttl;
		int                k;
		int                roll;
		int                bit_at;
		roll = $urandom_range(0, 99);
		if (roll < ((routes_sent < TABLE_DEPTH) ? 30 : 8)) begin
			addr = $urandom;
			if ($urandom_range(0, 99) < 12) begin
				plen = LEN_W'($urandom_range(33, 63));
			end else begin
				plen = LEN_W'($urandom_range(1, 32));
			end
			roll = $urandom_range(0, 99);
			if (routes_sent > 0 && roll < 50) begin
				k = $urandom_range(0, routes_sent - 1);
				if (roll < 12) begin
					// twin of an earlier route: the earlier one must keep winning
					addr = sent_prefix[k];
					plen = sent_len[k];
				end else begin
					m    = aim_mask(sent_len[k]);
					addr = (sent_prefix[k] & m) | (addr & ~m);
				end
			end
			// last free slot takes the catch-all route, so misses stay common till then
			if (routes_sent == TABLE_DEPTH - 1) begin
				plen = '0;
			end else if (routes_sent >= TABLE_DEPTH) begin
				plen = LEN_W'($urandom);
			end
			learn_route(addr, plen, 1'($urandom), $urandom, IFACE_W'($urandom));
		end else begin
			addr = $urandom;
			if (routes_sent > 0 && $urandom_range(0, 99) < 75) begin
				k    = $urandom_range(0, routes_sent - 1);
				m    = aim_mask(sent_len[k]);
				addr = (sent_prefix[k] & m) | (addr & ~m);
				// near miss: one bit inside the prefix flipped
				if (m != '0 && $urandom_range(0, 99) < 15) begin
					bit_at       = ADDR_W - $urandom_range(1, $countones(m));
					addr[bit_at] = ~addr[bit_at];
				end
			end
			if ($urandom_range(0, 99) < 12) begin
				ttl = TTL_W'($urandom_range(0, 2));
			end else begin
				ttl = TTL_W'($urandom);
			end
			route_dgram(addr, ttl);
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// watchdog: ends the run if no word moves for too long
	initial begin
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("watchdog: %0d cycles with no word accepted, %0d results outstanding",
		         QUIET_LIMIT, pending);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		req_ch.valid         <= 1'b0;
		req_ch.req_type      <= REQ_ADD;
		req_ch.address       <= '0;
		req_ch.prefix_len    <= '0;
		req_ch.has_next_hop  <= 1'b0;
		req_ch.gateway_addr  <= '0;
		req_ch.iface_in      <= '0;
		req_ch.ttl_in        <= '0;
		calm        = 1'b0;
		hold_rsp    = 1'b0;
		words_sent  = 0;
		routes_sent = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		route_dgram(32'h0000_0000, 8'd64);                             // empty table
		learn_route(32'h0A00_0000, 6'd8, 1'b1, 32'h0A00_0001, 3'd1);
		route_dgram(32'h0A01_0203, 8'd64);                             // via next hop
		route_dgram(32'h0A01_0203, 8'd1);                              // ttl one
		route_dgram(32'h0A01_0203, 8'd0);                              // ttl zero
		route_dgram(32'h0B00_0001, 8'd0);                              // miss beats low ttl
		learn_route(32'h0A01_0000, 6'd16, 1'b0, 32'hDEAD_BEEF, 3'd7);  // direct, hop ignored
		route_dgram(32'h0A01_0203, 8'd255);                            // longer prefix wins
		learn_route(32'h0A01_0000, 6'd16, 1'b1, 32'h0505_0505, 3'd2);  // equal length twin
		route_dgram(32'h0A01_0909, 8'd2);                              // earlier twin wins
		learn_route(32'hC0A8_0101, 6'd63, 1'b1, 32'hFFFF_FFFF, 3'd3);  // clamped to host route
		route_dgram(32'hC0A8_0101, 8'd255);
		route_dgram(32'hC0A8_0100, 8'd255);                            // host route misses
		learn_route(32'hFFFF_FFFF, 6'd33, 1'b1, 32'h0000_0000, 3'd0);
		route_dgram(32'hFFFF_FFFF, 8'd100);
		learn_route(32'h8000_0000, 6'd1, 1'b0, 32'h0000_0000, 3'd6);   // half of all space
		route_dgram(32'hFFFF_FFFE, 8'd128);
		route_dgram(32'h7FFF_FFFF, 8'd128);                            // other half misses
		route_dgram(32'h8000_0000, 8'd1);

		// random part; catch-all route lands in the last free slot
		for (int i = 0; i < WORDS_RANDOM; i++) begin
			calm = (i >= 700 && i < 1000);
			if (i == 300) begin
				// receiver holds off while words keep coming, the block backs up
				hold_rsp = 1'b1;
			end
			if (i == 1300) begin
				// sender waits for the block to drain completely
				req_ch.valid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
			random_word();
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d request words, %0d routes stored, %0d adds on a full table",
		         words_sent, tally[ST_ADDED], tally[ST_FULL]);
		$display("lookups: %0d forwarded, %0d no route, %0d low ttl; %0d mismatches",
		         tally[ST_FORWARDED], tally[ST_NO_ROUTE], tally[ST_TTL], mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### files.f
rtl/lpr_pkg.sv
rtl/lpr_if.sv
rtl/lpr_front.sv
rtl/lpr_queue.sv
rtl/lpr_back.sv
rtl/ipv4_longest_prefix_router_unit.sv
rtl/lpr_checker.sv
tb/lpr_route_checker.sv
tb/tb.sv
